/* sv/ssc_pkg.sv */
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, register indexes, reset values and the draw generator
// for the shot-noise synaptic conductance block.
// ----------------------------------------------------------------------------
package ssc_pkg;

  // field widths
  localparam int unsigned CmdW   = 1;
  localparam int unsigned VmW    = 16;
  localparam int unsigned CurW   = 48;
  localparam int unsigned CondW  = 32;
  localparam int unsigned DecayW = 16;
  localparam int unsigned ThrW   = 25;
  localparam int unsigned RevW   = 16;
  localparam int unsigned DrawW  = 24;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_EXC_DECAY     = 3'd0;
  localparam cfg_idx_t REG_INH_DECAY     = 3'd1;
  localparam cfg_idx_t REG_EXC_THRESHOLD = 3'd2;
  localparam cfg_idx_t REG_INH_THRESHOLD = 3'd3;
  localparam cfg_idx_t REG_EXC_QUANTUM   = 3'd4;
  localparam cfg_idx_t REG_INH_QUANTUM   = 3'd5;
  localparam cfg_idx_t REG_EXC_REVERSAL  = 3'd6;
  localparam cfg_idx_t REG_INH_REVERSAL  = 3'd7;

  // input commands
  localparam logic [CmdW-1:0] CMD_TICK   = 1'b0;
  localparam logic [CmdW-1:0] CMD_SAMPLE = 1'b1;

  // register reset values
  localparam logic [DecayW-1:0] RST_EXC_DECAY   = 16'hFFFF;
  localparam logic [DecayW-1:0] RST_INH_DECAY   = 16'hFFFF;
  localparam logic [ThrW-1:0]   RST_EXC_THR     = '0;
  localparam logic [ThrW-1:0]   RST_INH_THR     = '0;
  localparam logic [CondW-1:0]  RST_EXC_QUANTUM = 32'd131072;
  localparam logic [CondW-1:0]  RST_INH_QUANTUM = 32'd655360;
  localparam logic [RevW-1:0]   RST_EXC_REV     = 16'h0000;
  localparam logic [RevW-1:0]   RST_INH_REV     = 16'hB000;
  localparam logic [31:0]       RST_RNG         = 32'd1;

  // one xorshift32 (13,17,5) step
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

/* sv/ssc_in_if.sv */
// ----------------------------------------------------------------------------
// ssc_in_if
// Command channel: tick or sample, with the membrane potential.
// ----------------------------------------------------------------------------
interface ssc_in_if
  import ssc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CmdW-1:0]       command;
  logic signed [VmW-1:0] membrane_mv;

  modport source (output valid, output command, output membrane_mv, input ready);
  modport sink   (input valid, input command, input membrane_mv, output ready);
endinterface

/* sv/ssc_out_if.sv */
// ----------------------------------------------------------------------------
// ssc_out_if
// Result channel: synaptic current and both conductances.
// ----------------------------------------------------------------------------
interface ssc_out_if
  import ssc_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [CurW-1:0] current;
  logic [CondW-1:0]       exc_conductance;
  logic [CondW-1:0]       inh_conductance;

  modport source (output valid, output current, output exc_conductance,
                  output inh_conductance, input ready);
  modport sink   (input valid, input current, input exc_conductance,
                  input inh_conductance, output ready);
endinterface

/* sv/shotnoise_synaptic_conductance.sv */
// ----------------------------------------------------------------------------
// shotnoise_synaptic_conductance
// Excitatory and inhibitory shot-noise conductances with current readout.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries commands: tick advances both conductances one substep
//   (decay, two random draws, conditional quantum add); sample reports
//   Ge*(Ee-Vm) + Gi*(Ei-Vm) and both conductances on out_ch.
//   cfg_we/cfg_index/cfg_data write one register per cycle; any write
//   clears both conductances. Write only while the block is idle.
// Timing:
//   an accepted command is held in the stage register; a sample's result
//   then goes into the output register, where the receiver takes it.
//   One command per cycle is taken while no sample waits behind a result;
//   the conductance update loop runs from the state registers back to
//   them through one 32x16 multiply and a saturating add.
// Reset:
//   rst_n low clears both conductances, seeds the generator with one and
//   loads every register with its default.
// Stall:
//   while out_ch.ready is low and a result waits, ticks keep flowing; a
//   sample waits in the stage register and in_ch.ready drops behind it.
// ----------------------------------------------------------------------------
module shotnoise_synaptic_conductance
  import ssc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  ssc_in_if.sink              in_ch,
  ssc_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // configuration registers
  logic [DecayW-1:0]     exc_decay_r, inh_decay_r;
  logic [ThrW-1:0]       exc_thr_r, inh_thr_r;
  logic [CondW-1:0]      exc_quantum_r, inh_quantum_r;
  logic signed [RevW-1:0] exc_rev_r, inh_rev_r;

  // state
  logic [CondW-1:0] exc_g_r, inh_g_r;
  logic [31:0]      rng_r;

  // stage register
  logic                  s1_valid_r;
  logic [CmdW-1:0]       s1_cmd_r;
  logic signed [VmW-1:0] s1_vm_r;

  // output register
  logic                   out_valid_r;
  logic signed [CurW-1:0] out_current_r;
  logic [CondW-1:0]       out_exc_r, out_inh_r;

  logic s1_is_tick;
  logic s1_adv;
  logic in_fire;

  assign s1_is_tick = (s1_cmd_r == CMD_TICK);
  assign s1_adv     = s1_valid_r && (s1_is_tick || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire    = in_ch.valid && in_ch.ready;

  // tick datapath: random draws
  logic [31:0]      rng_e, rng_i;
  logic [DrawW-1:0] draw_e, draw_i;

  assign rng_e  = xorshift32(rng_r);
  assign rng_i  = xorshift32(rng_e);
  assign draw_e = rng_e[31:8];
  assign draw_i = rng_i[31:8];

  // tick datapath: decay and event add
  logic [CondW+DecayW-1:0] exc_prod, inh_prod;
  logic [CondW-1:0]        exc_dec, inh_dec;
  logic [CondW:0]          exc_sum, inh_sum;
  logic                    exc_hit, inh_hit;
  logic [CondW-1:0]        exc_g_nxt, inh_g_nxt;

  assign exc_prod = exc_g_r * exc_decay_r;
  assign inh_prod = inh_g_r * inh_decay_r;
  assign exc_dec  = exc_prod[CondW+DecayW-1:DecayW];
  assign inh_dec  = inh_prod[CondW+DecayW-1:DecayW];
  assign exc_hit  = {1'b0, draw_e} < exc_thr_r;
  assign inh_hit  = {1'b0, draw_i} < inh_thr_r;
  assign exc_sum  = {1'b0, exc_dec} + {1'b0, exc_quantum_r};
  assign inh_sum  = {1'b0, inh_dec} + {1'b0, inh_quantum_r};

  always_comb begin
    exc_g_nxt = exc_dec;
    if (exc_hit) begin
      exc_g_nxt = exc_sum[CondW] ? '1 : exc_sum[CondW-1:0];
    end
    inh_g_nxt = inh_dec;
    if (inh_hit) begin
      inh_g_nxt = inh_sum[CondW] ? '1 : inh_sum[CondW-1:0];
    end
  end

  // sample datapath: two products, sum, floor shift
  localparam int unsigned DiffW = RevW + 1;
  localparam int unsigned ProdW = CondW + DiffW + 1;
  localparam int unsigned SumW  = ProdW + 1;

  logic signed [DiffW-1:0] diff_e, diff_i;
  logic signed [ProdW-1:0] cur_prod_e, cur_prod_i;
  logic signed [SumW-1:0]  cur_sum;
  logic signed [SumW-1:0]  cur_shift;
  logic signed [CurW-1:0]  current_nxt;

  assign diff_e     = DiffW'(exc_rev_r) - DiffW'(s1_vm_r);
  assign diff_i     = DiffW'(inh_rev_r) - DiffW'(s1_vm_r);
  assign cur_prod_e = $signed({1'b0, exc_g_r}) * diff_e;
  assign cur_prod_i = $signed({1'b0, inh_g_r}) * diff_i;
  assign cur_sum    = SumW'(cur_prod_e) + SumW'(cur_prod_i);
  assign cur_shift  = cur_sum >>> 16;
  assign current_nxt = CurW'(cur_shift);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exc_decay_r   <= RST_EXC_DECAY;
      inh_decay_r   <= RST_INH_DECAY;
      exc_thr_r     <= RST_EXC_THR;
      inh_thr_r     <= RST_INH_THR;
      exc_quantum_r <= RST_EXC_QUANTUM;
      inh_quantum_r <= RST_INH_QUANTUM;
      exc_rev_r     <= RST_EXC_REV;
      inh_rev_r     <= RST_INH_REV;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXC_DECAY:     exc_decay_r   <= cfg_data[DecayW-1:0];
        REG_INH_DECAY:     inh_decay_r   <= cfg_data[DecayW-1:0];
        REG_EXC_THRESHOLD: exc_thr_r     <= cfg_data[ThrW-1:0];
        REG_INH_THRESHOLD: inh_thr_r     <= cfg_data[ThrW-1:0];
        REG_EXC_QUANTUM:   exc_quantum_r <= cfg_data[CondW-1:0];
        REG_INH_QUANTUM:   inh_quantum_r <= cfg_data[CondW-1:0];
        REG_EXC_REVERSAL:  exc_rev_r     <= cfg_data[RevW-1:0];
        REG_INH_REVERSAL:  inh_rev_r     <= cfg_data[RevW-1:0];
        default: ;
      endcase
    end
  end

  // conductance and generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exc_g_r <= '0;
      inh_g_r <= '0;
      rng_r   <= RST_RNG;
    end else if (cfg_we) begin
      exc_g_r <= '0;
      inh_g_r <= '0;
    end else if (s1_adv && s1_is_tick) begin
      exc_g_r <= exc_g_nxt;
      inh_g_r <= inh_g_nxt;
      rng_r   <= rng_i;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_ch.command;
      s1_vm_r  <= in_ch.membrane_mv;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && !s1_is_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_is_tick) begin
      out_current_r <= current_nxt;
      out_exc_r     <= exc_g_r;
      out_inh_r     <= inh_g_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.current         = out_current_r;
  assign out_ch.exc_conductance = out_exc_r;
  assign out_ch.inh_conductance = out_inh_r;

endmodule
